[hdl/vmb_pkg.sv]
// Shared types, codes and constants of the virtio-mmio block register front end.
package vmb_pkg;

    localparam int QUEUE_MAX_DEF = 256;
    localparam int CONFIG_BYTES  = 64;

    localparam int CAP_W     = 48;
    localparam int CFG_IDX_W = 1;
    localparam int ENT_OUT_W = 9;

    localparam logic [31:0] MAGIC_WORD  = 32'h7472_6976;
    localparam logic [31:0] VENDOR_WORD = 32'h554d_4551;
    localparam logic [31:0] VERSION_ID  = 32'd2;
    localparam logic [31:0] DEVICE_ID   = 32'd2;
    localparam int          FEAT_RO_BIT    = 5;
    localparam int          FEAT_FLUSH_BIT = 9;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_DONE  = 2'd2,
        CMD_NONE  = 2'd3
    } t_vmb_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_ONLY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'b1;

    localparam logic [8:0] OFF_MAGIC       = 9'h000;
    localparam logic [8:0] OFF_VERSION     = 9'h004;
    localparam logic [8:0] OFF_DEVICE_ID   = 9'h008;
    localparam logic [8:0] OFF_VENDOR_ID   = 9'h00c;
    localparam logic [8:0] OFF_DEV_FEAT    = 9'h010;
    localparam logic [8:0] OFF_DEV_FEAT_SEL = 9'h014;
    localparam logic [8:0] OFF_DRV_FEAT    = 9'h020;
    localparam logic [8:0] OFF_DRV_FEAT_SEL = 9'h024;
    localparam logic [8:0] OFF_QUEUE_SEL   = 9'h030;
    localparam logic [8:0] OFF_QUEUE_MAX   = 9'h034;
    localparam logic [8:0] OFF_QUEUE_NUM   = 9'h038;
    localparam logic [8:0] OFF_QUEUE_READY = 9'h044;
    localparam logic [8:0] OFF_QUEUE_NOTIFY = 9'h050;
    localparam logic [8:0] OFF_INT_STATUS  = 9'h060;
    localparam logic [8:0] OFF_INT_ACK     = 9'h064;
    localparam logic [8:0] OFF_STATUS      = 9'h070;
    localparam logic [8:0] OFF_DESC_LO     = 9'h080;
    localparam logic [8:0] OFF_DESC_HI     = 9'h084;
    localparam logic [8:0] OFF_AVAIL_LO    = 9'h090;
    localparam logic [8:0] OFF_AVAIL_HI    = 9'h094;
    localparam logic [8:0] OFF_USED_LO     = 9'h0a0;
    localparam logic [8:0] OFF_USED_HI     = 9'h0a4;

    // transport state except the queue size, whose width follows QUEUE_MAX
    typedef struct packed {
        logic [31:0] dev_status;
        logic [31:0] int_status;
        logic [31:0] dev_feature_page;
        logic [31:0] drv_feature_page;
        logic [63:0] drv_feature_bits;
        logic [31:0] queue_select;
        logic [31:0] queue_ready_word;
        logic [63:0] desc_addr;
        logic [63:0] avail_addr;
        logic [63:0] used_addr;
        logic        irq_line;
    } t_vmb_state;

endpackage

[hdl/vmb_read_mux.sv]
// Read data decode: identity words, banked feature words, queue words, interrupt and device status, and config space.
module vmb_read_mux
    import vmb_pkg::*;
(
    input  t_vmb_state         i_state,
    input  logic               i_read_only,
    input  logic [CAP_W-1:0]   i_capacity,
    input  logic [8:0]         i_offset,
    input  logic [3:0]         i_access_bytes,
    input  logic [31:0]        i_queue_max_word,
    output logic [63:0]        o_rdata
);

    logic [63:0] w_feats;
    logic [63:0] w_cap_ext;
    logic [63:0] w_cfg_data;

    always_comb begin
        w_feats = 64'd0;
        w_feats[32] = 1'b1;
        w_feats[FEAT_FLUSH_BIT] = 1'b1;
        w_feats[FEAT_RO_BIT] = i_read_only;
    end

    assign w_cap_ext = 64'(i_capacity);

    // config space: up to 8 bytes, only the capacity bytes are nonzero
    always_comb begin
        logic [8:0] b;
        w_cfg_data = 64'd0;
        for (int i = 0; i < 8; i++) begin
            b = {1'b0, i_offset[7:0]} + 9'(i);
            if ((4'(i) < i_access_bytes) && (b < 9'(CONFIG_BYTES)) && (b < 9'd8)) begin
                w_cfg_data[i*8 +: 8] = w_cap_ext[b[2:0]*8 +: 8];
            end
        end
    end

    always_comb begin
        if (i_offset[8]) begin
            o_rdata = w_cfg_data;
        end else begin
            unique case (i_offset)
                OFF_MAGIC:       o_rdata = 64'(MAGIC_WORD);
                OFF_VERSION:     o_rdata = 64'(VERSION_ID);
                OFF_DEVICE_ID:   o_rdata = 64'(DEVICE_ID);
                OFF_VENDOR_ID:   o_rdata = 64'(VENDOR_WORD);
                OFF_DEV_FEAT:    o_rdata = (i_state.dev_feature_page == 32'd1) ?
                                           {32'd0, w_feats[63:32]} : {32'd0, w_feats[31:0]};
                OFF_QUEUE_MAX:   o_rdata = (i_state.queue_select == 32'd0) ?
                                           64'(i_queue_max_word) : 64'd0;
                OFF_QUEUE_READY: o_rdata = 64'(i_state.queue_ready_word);
                OFF_INT_STATUS:  o_rdata = 64'(i_state.int_status);
                OFF_STATUS:      o_rdata = 64'(i_state.dev_status);
                default:         o_rdata = 64'd0;
            endcase
        end
    end

endmodule

[hdl/vmb_regs.sv]
// Transport and configuration registers with write decode and completion handling.
module vmb_regs
    import vmb_pkg::*;
#(
    parameter int QUEUE_MAX = QUEUE_MAX_DEF,
    parameter int QW        = $clog2(QUEUE_MAX + 1)
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CAP_W-1:0]     i_cfg_wdata,
    input  logic                 i_exec,
    input  t_vmb_cmd             i_cmd,
    input  logic [8:0]           i_offset,
    input  logic [31:0]          i_wdata,
    output t_vmb_state           o_state,
    output logic [QW-1:0]        o_entries,
    output t_vmb_state           o_next,
    output logic [QW-1:0]        o_next_entries,
    output logic                 o_notify,
    output logic                 o_read_only,
    output logic [CAP_W-1:0]     o_capacity
);

    t_vmb_state       r_st, n_st;
    logic [QW-1:0]    r_entries, n_entries;
    logic             r_read_only;
    logic [CAP_W-1:0] r_capacity;
    logic             w_queue_live;
    logic [31:0]      w_int_acked;

    assign w_queue_live = (r_st.queue_ready_word != 32'd0) && (r_entries != '0);
    assign w_int_acked  = r_st.int_status & ~i_wdata;

    always_comb begin
        n_st      = r_st;
        n_entries = r_entries;
        o_notify  = 1'b0;
        if (i_cmd == CMD_WRITE) begin
            unique case (i_offset)
                OFF_DEV_FEAT_SEL: n_st.dev_feature_page = i_wdata;
                OFF_DRV_FEAT: begin
                    if (r_st.drv_feature_page == 32'd1) begin
                        n_st.drv_feature_bits[63:32] = i_wdata;
                    end else begin
                        n_st.drv_feature_bits[31:0] = i_wdata;
                    end
                end
                OFF_DRV_FEAT_SEL: n_st.drv_feature_page = i_wdata;
                OFF_QUEUE_SEL:    n_st.queue_select = i_wdata;
                OFF_QUEUE_NUM:    n_entries = (i_wdata > 32'(QUEUE_MAX)) ?
                                              QW'(QUEUE_MAX) : i_wdata[QW-1:0];
                OFF_QUEUE_READY:  n_st.queue_ready_word = i_wdata;
                OFF_QUEUE_NOTIFY: o_notify = (i_wdata == 32'd0) && w_queue_live;
                OFF_INT_ACK: begin
                    n_st.int_status = w_int_acked;
                    if (w_int_acked == 32'd0) begin
                        n_st.irq_line = 1'b0;
                    end
                end
                OFF_STATUS: begin
                    if (i_wdata == 32'd0) begin
                        n_st      = '0;
                        n_entries = '0;
                    end else begin
                        n_st.dev_status = i_wdata;
                    end
                end
                OFF_DESC_LO:  n_st.desc_addr[31:0]   = i_wdata;
                OFF_DESC_HI:  n_st.desc_addr[63:32]  = i_wdata;
                OFF_AVAIL_LO: n_st.avail_addr[31:0]  = i_wdata;
                OFF_AVAIL_HI: n_st.avail_addr[63:32] = i_wdata;
                OFF_USED_LO:  n_st.used_addr[31:0]   = i_wdata;
                OFF_USED_HI:  n_st.used_addr[63:32]  = i_wdata;
                default: ;
            endcase
        end else if (i_cmd == CMD_DONE) begin
            if (w_queue_live) begin
                n_st.int_status = r_st.int_status | 32'd1;
                n_st.irq_line   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= '0;
            r_entries <= '0;
        end else if (i_exec) begin
            r_st      <= n_st;
            r_entries <= n_entries;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_only <= 1'b0;
            r_capacity  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_READ_ONLY: r_read_only <= i_cfg_wdata[0];
                CFG_CAPACITY:  r_capacity  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_state        = r_st;
    assign o_entries      = r_entries;
    assign o_next         = n_st;
    assign o_next_entries = n_entries;
    assign o_read_only    = r_read_only;
    assign o_capacity     = r_capacity;

endmodule

[hdl/virtio_mmio_block_registers_unit.sv]
// Top level of the virtio-mmio block register front end: input stage, execute, result register.
//
// Each bus access or completion event passes through an input register, is decoded
// against the transport registers combinationally, and lands in a result register;
// one item is accepted per cycle as long as the result side keeps taking results.
// The result register holds while the output is stalled, and the input register then
// holds one more item before input stalls. The result carries read data (zero unless
// a read), the interrupt level, the notify strobe and the queue size and ring bases as
// they stand after the item. A status write of zero clears all transport state;
// configuration registers are kept.
module virtio_mmio_block_registers_unit
    import vmb_pkg::*;
#(
    parameter int QUEUE_MAX = QUEUE_MAX_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CAP_W-1:0]     i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_cmd,
    input  logic [8:0]           i_offset,
    input  logic [3:0]           i_access_bytes,
    input  logic [31:0]          i_wdata,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [63:0]          o_rdata,
    output logic                 o_irq_level,
    output logic                 o_notify,
    output logic [ENT_OUT_W-1:0] o_ring_entries,
    output logic [63:0]          o_desc_base,
    output logic [63:0]          o_avail_base,
    output logic [63:0]          o_used_base
);

    localparam int QW = $clog2(QUEUE_MAX + 1);

    logic        r_in_valid;
    t_vmb_cmd    r_in_cmd;
    logic [8:0]  r_in_offset;
    logic [3:0]  r_in_bytes;
    logic [31:0] r_in_wdata;

    logic        r_out_valid;
    logic [63:0] r_out_rdata;
    logic        r_out_irq;
    logic        r_out_notify;
    logic [ENT_OUT_W-1:0] r_out_entries;
    logic [63:0] r_out_desc;
    logic [63:0] r_out_avail;
    logic [63:0] r_out_used;

    logic             w_adv;
    t_vmb_state       w_state, w_next;
    logic [QW-1:0]    w_entries, w_next_entries;
    logic             w_notify;
    logic             w_read_only;
    logic [CAP_W-1:0] w_capacity;
    logic [63:0]      w_rdata;
    logic [31:0]      w_entries_ext;

    // execute when an item waits and the result register is free or being drained
    assign w_adv   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_cmd    <= t_vmb_cmd'(i_cmd);
            r_in_offset <= i_offset;
            r_in_bytes  <= i_access_bytes;
            r_in_wdata  <= i_wdata;
        end
    end

    vmb_regs #(
        .QUEUE_MAX (QUEUE_MAX),
        .QW        (QW)
    ) u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_exec         (w_adv),
        .i_cmd          (r_in_cmd),
        .i_offset       (r_in_offset),
        .i_wdata        (r_in_wdata),
        .o_state        (w_state),
        .o_entries      (w_entries),
        .o_next         (w_next),
        .o_next_entries (w_next_entries),
        .o_notify       (w_notify),
        .o_read_only    (w_read_only),
        .o_capacity     (w_capacity)
    );

    vmb_read_mux u_read_mux (
        .i_state          (w_state),
        .i_read_only      (w_read_only),
        .i_capacity       (w_capacity),
        .i_offset         (r_in_offset),
        .i_access_bytes   (r_in_bytes),
        .i_queue_max_word (32'(QUEUE_MAX)),
        .o_rdata          (w_rdata)
    );

    assign w_entries_ext = 32'(w_next_entries);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_rdata   <= (r_in_cmd == CMD_READ) ? w_rdata : 64'd0;
            r_out_irq     <= w_next.irq_line;
            r_out_notify  <= w_notify;
            r_out_entries <= w_entries_ext[ENT_OUT_W-1:0];
            r_out_desc    <= w_next.desc_addr;
            r_out_avail   <= w_next.avail_addr;
            r_out_used    <= w_next.used_addr;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_rdata        = r_out_rdata;
    assign o_irq_level    = r_out_irq;
    assign o_notify       = r_out_notify;
    assign o_ring_entries = r_out_entries;
    assign o_desc_base    = r_out_desc;
    assign o_avail_base   = r_out_avail;
    assign o_used_base    = r_out_used;

    // input side only stalls when both stages hold an item
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free stage");

    // status write of zero leaves transport state cleared
    a_status_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_cmd == CMD_WRITE && r_in_offset == OFF_STATUS && r_in_wdata == 32'd0)
        |=> (w_state == '0 && w_entries == '0))
        else $error("status reset did not clear state");

    // queue size never exceeds the maximum
    a_entries_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_entries) <= 32'(QUEUE_MAX))
        else $error("queue size above maximum");

    // interrupt line only high with a pending interrupt bit
    a_irq_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_state.irq_line |-> (w_state.int_status != 32'd0))
        else $error("interrupt line high with no pending bit");

endmodule
